@@ rtl/smt_pkg.sv @@
`default_nettype none

package smt_pkg;

   localparam int unsigned ValueWidth  = 32;
   localparam int unsigned CountWidth  = 7;
   localparam int unsigned StatusWidth = 3;

   // operation codes carried in the request tuser
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_READ   = 2'd2
   } op_type;

   // status codes carried in the response tuser
   typedef enum logic [StatusWidth-1:0] {
      ST_DONE       = 3'd0,
      ST_FULL       = 3'd1,
      ST_NOT_FOUND  = 3'd2,
      ST_READ_VALUE = 3'd3,
      ST_READ_EMPTY = 3'd4
   } status_type;

   // command broadcast to every cell of the chain
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type          cmd;
      logic                  found;
      logic [ValueWidth-1:0] head;
   } cell_ctl_type;

   // what one cell shows its neighbors
   typedef struct packed {
      logic                  valid;
      logic                  ge;
      logic [ValueWidth-1:0] data;
   } cell_link_type;

endpackage

`default_nettype wire

@@ rtl/smt_cell.sv @@
`default_nettype none

module smt_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  smt_pkg::cell_ctl_type  ctl,
   input  logic [smt_pkg::ValueWidth-1:0] value,
   input  smt_pkg::cell_link_type left_link,
   input  smt_pkg::cell_link_type right_link,
   output smt_pkg::cell_link_type link,
   output logic                 eq
);
   import smt_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   logic [ValueWidth-1:0] data_ff;
   logic [ValueWidth-1:0] data_in;
   logic                  ge;

   // compare the broadcast value against the held entry
   assign ge   = valid_ff && ($signed(value) <= $signed(data_ff));
   assign eq   = valid_ff && (value == data_ff);
   assign link = '{valid: valid_ff, ge: ge, data: data_ff};

   // next entry from the neighbors or the broadcast
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      case (ctl.cmd)
         CELL_INSERT: begin
            if (left_link.ge) begin
               data_in  = left_link.data;
               valid_in = 1'b1;
            end else if (ge || (!valid_ff && left_link.valid)) begin
               data_in  = value;
               valid_in = 1'b1;
            end
         end
         CELL_DELETE: begin
            if (ctl.found && ge) begin
               data_in  = right_link.data;
               valid_in = right_link.valid;
            end
         end
         CELL_ROTATE: begin
            if (valid_ff) begin
               data_in = right_link.valid ? right_link.data : ctl.head;
            end
         end
         default: begin
         end
      endcase
   end

   // occupancy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // entry payload
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

@@ rtl/sorted_multiset_table.sv @@
// insert and delete: response beat registered in the cycle after the request beat
// insert and delete: one request beat per cycle when the response side keeps up
// readout: one rotation step of the cell ring per cycle unless rsp_tready stalls it
// readout: one response beat per distinct value, each held while rsp_tready is low
// reset: synchronous, clears the count and all cell valid flags
`default_nettype none

module sorted_multiset_table #(
   parameter int unsigned DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // value[31:0]
   input  logic [1:0]  req_tuser,  // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // count[6:0], value_out[38:7], zero pad[39]
   output logic [2:0]  rsp_tuser,  // status[2:0]
   output logic        rsp_tlast
);
   import smt_pkg::*;

   localparam int unsigned CW = $clog2(DEPTH + 1);

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         step_ff, step_in;
   logic [ValueWidth-1:0] pend_ff, pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [CW-1:0]         rsp_count_ff, rsp_count_in;
   logic [ValueWidth-1:0] rsp_value_ff, rsp_value_in;
   logic                  rsp_last_ff, rsp_last_in;

   cell_ctl_type          ctl;
   cell_link_type         links [DEPTH];
   cell_link_type         left_links [DEPTH];
   cell_link_type         right_links [DEPTH];
   logic [DEPTH-1:0]      eq_vec;
   logic [DEPTH-1:0]      valid_vec;

   logic                  out_free;
   logic                  accept;
   op_type                op;
   logic                  full;
   logic                  found;
   logic                  rotate;
   logic [ValueWidth-1:0] head;

   // handshake
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign op         = op_type'(req_tuser);
   assign full       = (count_ff == CW'(DEPTH));
   assign found      = |eq_vec;
   assign head       = links[0].data;

   // chain of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_links[i] = '{valid: 1'b1, ge: 1'b0, data: '0};
      end else begin : g_mid
         assign left_links[i] = links[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_links[i] = '{valid: 1'b0, ge: 1'b0, data: '0};
      end else begin : g_body
         assign right_links[i] = links[i+1];
      end
      assign valid_vec[i] = links[i].valid;

      smt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .value      (req_tdata),
         .left_link  (left_links[i]),
         .right_link (right_links[i]),
         .link       (links[i]),
         .eq         (eq_vec[i])
      );
   end

   // cell commands, next state and response beat
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      rotate        = 1'b0;
      ctl.cmd       = CELL_HOLD;
      ctl.found     = found;
      ctl.head      = head;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (op)
                  OP_INSERT: begin
                     rsp_valid_in = 1'b1;
                     rsp_value_in = '0;
                     rsp_last_in  = 1'b1;
                     if (full) begin
                        rsp_status_in = ST_FULL;
                        rsp_count_in  = count_ff;
                     end else begin
                        ctl.cmd       = CELL_INSERT;
                        count_in      = count_ff + 1'b1;
                        rsp_status_in = ST_DONE;
                        rsp_count_in  = count_ff + 1'b1;
                     end
                  end
                  OP_DELETE: begin
                     ctl.cmd      = CELL_DELETE;
                     rsp_valid_in = 1'b1;
                     rsp_value_in = '0;
                     rsp_last_in  = 1'b1;
                     if (found) begin
                        count_in      = count_ff - 1'b1;
                        rsp_status_in = ST_DONE;
                        rsp_count_in  = count_ff - 1'b1;
                     end else begin
                        rsp_status_in = ST_NOT_FOUND;
                        rsp_count_in  = count_ff;
                     end
                  end
                  OP_READ: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_READ_EMPTY;
                        rsp_count_in  = '0;
                        rsp_value_in  = '0;
                        rsp_last_in   = 1'b1;
                     end else begin
                        state_in = S_READ;
                        step_in  = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            if (step_ff == count_ff) begin
               // ring is back in order, flush the held value as the final beat
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_READ_VALUE;
                  rsp_count_in  = count_ff;
                  rsp_value_in  = pend_ff;
                  rsp_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end
            end else if ((step_ff == '0) || (head == pend_ff)) begin
               rotate  = 1'b1;
               pend_in = head;
               step_in = step_ff + 1'b1;
            end else if (out_free) begin
               // new distinct value, so the held one is not the last
               rotate        = 1'b1;
               pend_in       = head;
               step_in       = step_ff + 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_READ_VALUE;
               rsp_count_in  = count_ff;
               rsp_value_in  = pend_ff;
               rsp_last_in   = 1'b0;
            end
            if (rotate) begin
               ctl.cmd = CELL_ROTATE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_ff       <= pend_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // response ports
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {1'b0, rsp_value_ff, CountWidth'(rsp_count_ff)};

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == 32'(count_ff))
      else $error("cell valid flags disagree with entry count");

   a_no_request_in_readout: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> !req_tready)
      else $error("request taken during readout");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_FULL |-> rsp_count_ff == CW'(DEPTH))
      else $error("full drop reported with wrong count");

   a_rotate_only_in_readout: assert property (@(posedge clock) disable iff (reset)
      ctl.cmd == CELL_ROTATE |-> state_ff == S_READ && step_ff != count_ff)
      else $error("ring rotated outside a readout");
`endif

endmodule

`default_nettype wire

@@ verif/smt_checker.sv @@
`default_nettype none

module smt_checker #(
   parameter int unsigned DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // value[31:0]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // count[6:0], value_out[38:7], zero pad[39]
   input  logic [2:0]  rsp_tuser,   // status[2:0]
   input  logic        rsp_tlast,
   output int          mismatches,
   output int          outstanding,
   output int          beats_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   import smt_pkg::*;

   typedef struct {
      status_type                   status;
      logic [CountWidth-1:0]        count;
      logic signed [ValueWidth-1:0] value;
      logic                         last;
   } result_beat_type;

   // shadow copy of the sorted table
   logic signed [ValueWidth-1:0] entries [DEPTH];
   int                           entry_total = 0;

   // results still owed by the block, oldest first
   result_beat_type pending_results [$];

   int err_total  = 0;
   int beat_total = 0;

   // work out the response beats of one accepted request beat
   task automatic apply_table_op(input logic [1:0] op, input logic signed [ValueWidth-1:0] v);
      int              pos;
      result_beat_type beat;
      beat.status = ST_DONE;
      beat.count  = '0;
      beat.value  = '0;
      beat.last   = 1'b1;
      pos         = entry_total;
      case (op)
         OP_INSERT: begin
            if (entry_total >= DEPTH) begin
               beat.status = ST_FULL;
            end else begin
               // land in front of the first entry that is greater or equal
               for (int i = 0; i < entry_total; i++) begin
                  if (pos == entry_total && v <= entries[i]) pos = i;
               end
               for (int i = entry_total; i > pos; i--) entries[i] = entries[i-1];
               entries[pos] = v;
               entry_total++;
            end
            beat.count = CountWidth'(entry_total);
            pending_results.push_back(beat);
         end
         OP_DELETE: begin
            for (int i = 0; i < entry_total; i++) begin
               if (pos == entry_total && entries[i] == v) pos = i;
            end
            if (pos == entry_total) begin
               beat.status = ST_NOT_FOUND;
            end else begin
               for (int i = pos; i + 1 < entry_total; i++) entries[i] = entries[i+1];
               entry_total--;
            end
            beat.count = CountWidth'(entry_total);
            pending_results.push_back(beat);
         end
         OP_READ: begin
            if (entry_total == 0) begin
               beat.status = ST_READ_EMPTY;
               pending_results.push_back(beat);
            end else begin
               // one beat per distinct value, the final one marked
               beat.status = ST_READ_VALUE;
               beat.count  = CountWidth'(entry_total);
               beat.last   = 1'b0;
               for (int i = 0; i < entry_total; i++) begin
                  if (i == 0 || entries[i] != entries[i-1]) begin
                     beat.value = entries[i];
                     pending_results.push_back(beat);
                  end
               end
               pending_results[pending_results.size()-1].last = 1'b1;
            end
         end
         default: begin
            // undefined operation: dropped without a response
         end
      endcase
   endtask

   // compare response beats first, then predict from the request beat
   always @(posedge clock) begin
      result_beat_type              want;
      logic [CountWidth-1:0]        got_count;
      logic signed [ValueWidth-1:0] got_value;
      got_count = rsp_tdata[CountWidth-1:0];
      got_value = rsp_tdata[CountWidth+ValueWidth-1:CountWidth];
      if (reset) begin
         entry_total = 0;
         pending_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            beat_total++;
            if (pending_results.size() == 0) begin
               err_total++;
               $display("%0t: unexpected response beat: status %0d count %0d value %0d last %0b",
                        $time, rsp_tuser, got_count, got_value, rsp_tlast);
            end else begin
               want = pending_results.pop_front();
               if (rsp_tuser !== want.status) begin
                  err_total++;
                  $display("%0t: status expected %0d got %0d", $time, want.status, rsp_tuser);
               end
               if (got_count !== want.count) begin
                  err_total++;
                  $display("%0t: count expected %0d got %0d", $time, want.count, got_count);
               end
               if (got_value !== want.value) begin
                  err_total++;
                  $display("%0t: value expected %0d got %0d", $time, want.value, got_value);
               end
               if (rsp_tlast !== want.last) begin
                  err_total++;
                  $display("%0t: last expected %0b got %0b", $time, want.last, rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            apply_table_op(req_tuser, $signed(req_tdata));
         end
      end
      mismatches  <= err_total;
      outstanding <= pending_results.size();
      beats_seen  <= beat_total;
   end

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import smt_pkg::*;

   localparam int unsigned Depth       = 16;
   localparam logic [1:0]  OpUndefined = 2'd3;
   localparam int          RandomItems = 480;
   localparam int          IdleLimit   = 4000;
   localparam int          LongHold    = 400;
   localparam int          HoldAfter   = 80;
   localparam int          DrainCycles = 2 * Depth + 8;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = OP_INSERT;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [39:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   int mismatches;
   int outstanding;
   int beats_seen;

   int n_insert  = 0;
   int n_delete  = 0;
   int n_read    = 0;
   int n_ignored = 0;
   int idle_run  = 0;

   always #5 clock = ~clock;

   sorted_multiset_table #(
      .DEPTH(Depth)
   ) u_top (
      .clock,
      .reset,
      .req_tvalid,
      .req_tready,
      .req_tdata,
      .req_tuser,
      .rsp_tvalid,
      .rsp_tready,
      .rsp_tdata,
      .rsp_tuser,
      .rsp_tlast
   );

   smt_checker #(
      .DEPTH(Depth)
   ) u_checker (
      .clock,
      .reset,
      .req_tvalid,
      .req_tready,
      .req_tdata,
      .req_tuser,
      .rsp_tvalid,
      .rsp_tready,
      .rsp_tdata,
      .rsp_tuser,
      .rsp_tlast,
      .mismatches,
      .outstanding,
      .beats_seen
   );

   // offer one request beat and hold it until accepted
   task automatic send_item(input logic [1:0] op, input logic signed [31:0] v);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= v;
      do @(posedge clock); while (!req_tready);
      case (op)
         OP_INSERT: n_insert++;
         OP_DELETE: n_delete++;
         OP_READ:   n_read++;
         default:   n_ignored++;
      endcase
   endtask

   task automatic idle_cycles(input int n);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // stop offering and wait until every owed response has arrived
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // reset and the request side
   initial begin : req_side
      logic signed [31:0] pool [8];
      logic [1:0]         op;
      logic signed [31:0] v;
      int                 made;
      int                 bias;
      int                 gap_style;
      int                 burst_left;
      int                 pick;
      bit                 paused;
      made       = 0;
      burst_left = 0;
      bias       = 0;
      gap_style  = 0;
      paused     = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, undefined code, extremes, duplicates, full table
      send_item(OP_READ, 32'sd0);
      send_item(OP_DELETE, 32'sd5);
      send_item(OpUndefined, 32'sd77);
      send_item(OP_INSERT, 32'sh7fffffff);
      send_item(OP_INSERT, 32'sh80000000);
      send_item(OP_INSERT, 32'sd0);
      send_item(OP_INSERT, -32'sd1);
      send_item(OP_INSERT, 32'sh7fffffff);
      send_item(OP_READ, 32'shffffffff);
      send_item(OP_DELETE, 32'sd7);
      send_item(OP_DELETE, 32'sh80000000);
      for (int k = 0; k < 12; k++) begin
         send_item(OP_INSERT, (k % 5) * 1000 - 2000);
      end
      send_item(OP_INSERT, 32'sd123);
      send_item(OP_READ, 32'sd0);

      // random: phases that fill, drain or mix the table
      while (made < RandomItems) begin
         if (made % 40 == 0) begin
            bias      = $urandom_range(0, 2);
            gap_style = $urandom_range(0, 2);
            for (int k = 0; k < 8; k++) begin
               case ($urandom_range(0, 3))
                  0:       pool[k] = $urandom;
                  1:       pool[k] = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
                  default: pool[k] = $signed($urandom_range(0, 40)) - 20;
               endcase
            end
         end
         if (!paused && made == RandomItems / 2) begin
            paused = 1'b1;
            wait_drained();
         end
         // bursts separated by random gaps
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            case (gap_style)
               0:       idle_cycles(0);
               1:       idle_cycles($urandom_range(0, 3));
               default: idle_cycles($urandom_range(1, 8));
            endcase
         end
         burst_left--;
         pick = $urandom_range(0, 99);
         case (bias)
            0:       op = pick < 70 ? OP_INSERT : pick < 85 ? OP_DELETE : OP_READ;
            1:       op = pick < 15 ? OP_INSERT : pick < 85 ? OP_DELETE : OP_READ;
            default: op = pick < 40 ? OP_INSERT : pick < 75 ? OP_DELETE : OP_READ;
         endcase
         if (pick % 33 == 7) op = OpUndefined;
         v = $urandom_range(0, 9) < 7 ? pool[$urandom_range(0, 7)] : $signed($urandom);
         send_item(op, v);
         if (op != OpUndefined) made++;
      end

      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      $display("covered %0d inserts, %0d deletes, %0d readouts, %0d undefined codes",
               n_insert, n_delete, n_read, n_ignored);
      $display("%0d response beats checked, %0d mismatches", beats_seen, mismatches);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // response side: changing stall patterns and one long hold-off
   initial begin : rsp_side
      int mode;
      int span;
      int phase;
      bit held;
      phase = 0;
      held  = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 200);
         repeat (span) begin
            if (!held && !reset && beats_seen >= HoldAfter) begin
               held = 1'b1;
               rsp_tready <= 1'b0;
               repeat (LongHold) @(posedge clock);
            end
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= $urandom_range(0, 9) < 7;
               2:       rsp_tready <= $urandom_range(0, 9) < 3;
               default: rsp_tready <= (phase % 5) != 0;
            endcase
            phase++;
            @(posedge clock);
         end
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_run <= 0;
      end else if (idle_run >= IdleLimit) begin
         $display("timeout after %0d cycles without a beat", idle_run);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_run <= idle_run + 1;
      end
   end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/smt_pkg.sv
rtl/smt_cell.sv
rtl/sorted_multiset_table.sv
verif/smt_checker.sv
verif/testbench.sv
